>>> rtl/sca_pkg.sv
package sca_pkg;

    // channel table size
    localparam int MAX_CHANNELS = 8;
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // field widths fixed by the interface
    localparam int CFG_W    = 4;
    localparam int KIND_W   = 2;
    localparam int ORIGIN_W = 16;
    localparam int PRIO_W   = 8;
    localparam int IDX_W    = 3;

    // reset channel count
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

    // request kinds
    localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STOP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    typedef logic [MAX_CHANNELS-1:0] t_chan_vec;

endpackage

>>> rtl/sound_channel_allocator_top.sv
// Voice channel allocator. Each item (start, stop by origin, release by index) is
// latched at the edge where start is high, is resolved against the channel table in
// the following cycle, and its result is registered and shows on the o_ result ports
// with o_done high for exactly one cycle. busy stays low, so an item may be issued in
// every cycle; the table update of one item is seen by the next one. The result cannot
// be held off: sample it in the o_done cycle. active_channels is written through the
// cfg channel (always ready) by the user only while no item is in flight (the block
// does not enforce it); 0 acts as 1, values above the table size act as the table size.
module sound_channel_allocator_top
    import sca_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [ORIGIN_W-1:0] i_origin_id,
    input  logic [PRIO_W-1:0]   i_priority_req,
    input  logic [IDX_W-1:0]    i_channel,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output logic                o_done,
    output logic                o_granted,
    output logic [IDX_W-1:0]    o_granted_channel,
    output logic                o_evicted,
    output logic [IDX_W-1:0]    o_evicted_channel,
    output logic                o_stopped,
    output logic [IDX_W-1:0]    o_stopped_channel
);

    // control registers
    logic                r_req_valid;
    logic [CFG_W-1:0]    r_active;
    t_chan_vec           r_busy;
    t_chan_vec           n_busy;

    // input register
    logic [KIND_W-1:0]   r_kind;
    logic [ORIGIN_W-1:0] r_origin;
    logic [PRIO_W-1:0]   r_prio;
    logic [IDX_W-1:0]    r_channel;

    // channel table payload
    logic [ORIGIN_W-1:0] r_ch_origin [MAX_CHANNELS];
    logic [PRIO_W-1:0]   r_ch_prio   [MAX_CHANNELS];

    // result register
    logic                r_done;
    logic                r_granted;
    logic [CH_W-1:0]     r_gch;
    logic                r_evicted;
    logic [CH_W-1:0]     r_ech;
    logic                r_stopped;
    logic [CH_W-1:0]     r_sch;

    logic                n_granted;
    logic [CH_W-1:0]     n_gch;
    logic                n_evicted;
    logic [CH_W-1:0]     n_ech;
    logic                n_stopped;
    logic [CH_W-1:0]     n_sch;

    logic [CFG_W-1:0]    live;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // effective channel count
    always_comb begin
        if (r_active == '0) begin
            live = CFG_W'(1);
        end else if (int'(r_active) > MAX_CHANNELS) begin
            live = CFG_W'(MAX_CHANNELS);
        end else begin
            live = r_active;
        end
    end

    // allocation logic
    always_comb begin
        t_chan_vec       act;
        t_chan_vec       match;
        t_chan_vec       rel_hit;
        t_chan_vec       busy_mid;
        t_chan_vec       free_v;
        t_chan_vec       evict_v;
        logic [CH_W-1:0] m_idx;
        logic [CH_W-1:0] f_idx;
        logic [CH_W-1:0] e_idx;
        logic [CH_W-1:0] r_idx;

        m_idx = '0;
        f_idx = '0;
        e_idx = '0;
        r_idx = '0;

        // per-channel compares
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            act[c]     = (c < int'(live));
            match[c]   = act[c] && r_busy[c] && (r_ch_origin[c] == r_origin);
            rel_hit[c] = act[c] && r_busy[c] && (c == int'(r_channel));
            evict_v[c] = act[c] && (r_ch_prio[c] >= r_prio);
        end

        // lowest origin match
        for (int c = MAX_CHANNELS - 1; c >= 0; c--) begin
            if (match[c]) begin
                m_idx = CH_W'(c);
            end
        end

        // table after the origin match is freed
        busy_mid = r_busy;
        if (|match) begin
            busy_mid[m_idx] = 1'b0;
        end

        for (int c = 0; c < MAX_CHANNELS; c++) begin
            free_v[c] = act[c] && !busy_mid[c];
        end

        // lowest free, lowest evictable and lowest release-hit channel
        for (int c = MAX_CHANNELS - 1; c >= 0; c--) begin
            if (free_v[c]) begin
                f_idx = CH_W'(c);
            end
            if (evict_v[c]) begin
                e_idx = CH_W'(c);
            end
            if (rel_hit[c]) begin
                r_idx = CH_W'(c);
            end
        end

        n_busy    = r_busy;
        n_granted = 1'b0;
        n_gch     = '0;
        n_evicted = 1'b0;
        n_ech     = '0;
        n_stopped = 1'b0;
        n_sch     = '0;

        unique case (r_kind)
            KIND_START: begin
                n_stopped = |match;
                n_sch     = (|match) ? m_idx : '0;
                n_busy    = busy_mid;
                if (|free_v) begin
                    n_granted = 1'b1;
                    n_gch     = f_idx;
                end else if (|evict_v) begin
                    n_granted = 1'b1;
                    n_gch     = e_idx;
                    n_evicted = 1'b1;
                    n_ech     = e_idx;
                end
                if (n_granted) begin
                    n_busy[n_gch] = 1'b1;
                end
            end
            KIND_STOP: begin
                n_stopped = |match;
                n_sch     = (|match) ? m_idx : '0;
                n_busy    = busy_mid;
            end
            KIND_RELEASE: begin
                if (|rel_hit) begin
                    n_stopped      = 1'b1;
                    n_sch          = r_idx;
                    n_busy[r_idx]  = 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (!r_req_valid) begin
            n_busy = r_busy;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_done      <= 1'b0;
            r_active    <= ACTIVE_RESET;
            r_busy      <= '0;
        end else begin
            r_req_valid <= start;
            r_done      <= r_req_valid;
            r_busy      <= n_busy;
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
        end
    end

    // input and result payload
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_kind    <= i_kind;
            r_origin  <= i_origin_id;
            r_prio    <= i_priority_req;
            r_channel <= i_channel;
        end
        r_granted <= n_granted;
        r_gch     <= n_gch;
        r_evicted <= n_evicted;
        r_ech     <= n_ech;
        r_stopped <= n_stopped;
        r_sch     <= n_sch;
    end

    // table entries written on grant
    always_ff @(posedge i_clk) begin
        if (r_req_valid && n_granted) begin
            r_ch_origin[n_gch] <= r_origin;
            r_ch_prio[n_gch]   <= r_prio;
        end
    end

    // result ports
    assign o_done            = r_done;
    assign o_granted         = r_done && r_granted;
    assign o_granted_channel = r_done ? IDX_W'(r_gch) : '0;
    assign o_evicted         = r_done && r_evicted;
    assign o_evicted_channel = r_done ? IDX_W'(r_ech) : '0;
    assign o_stopped         = r_done && r_stopped;
    assign o_stopped_channel = r_done ? IDX_W'(r_sch) : '0;

    // granted channel is marked busy when the result shows
    a_grant_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_granted) |-> r_busy[r_gch])
        else $error("granted channel not busy");

    // eviction always comes with a grant of the same channel
    a_evict_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_evicted) |-> (o_granted && (r_gch == r_ech)))
        else $error("eviction without matching grant");

    // a channel freed by origin match leaves room, so no eviction follows
    a_no_evict_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_evicted && o_stopped))
        else $error("eviction after origin free");

    // a freed channel that was not regranted is free
    a_stop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_stopped && !o_granted) |-> !r_busy[r_sch])
        else $error("stopped channel still busy");

    // every accepted item is followed by a result on o_done
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("missing result");

endmodule
